/* rtl/core/pva_pkg.sv */
// package for the polar vector adder: formats, cordic constants and stage types
`timescale 1ns / 1ps
`default_nettype none
package pva_pkg;

   // internal widths
   localparam int unsigned GuardBits   = 12;
   localparam int unsigned TableLen    = 24;
   localparam int unsigned VecW        = 48;   // x/y datapath width
   localparam int unsigned AngW        = 40;   // angle width, 30 fraction bits
   localparam int unsigned MagMax      = 131071;
   // magnitude lsb is the same on input and output, so no rescale follows from it
   localparam int unsigned MagFracBits = 8;

   typedef logic signed [VecW-1:0] vec_type;
   typedef logic signed [AngW-1:0] ang_type;

   localparam ang_type PiQ30     = 40'sd3373259426;
   localparam ang_type HalfPiQ30 = 40'sd1686629713;
   localparam ang_type TwoPiQ30  = 40'sd6746518852;

   // one word carried between cordic cells
   typedef struct packed {
      logic    valid;
      vec_type x;
      vec_type y;
      ang_type z;
   } cell_type;

   // atan(2^-i) with 30 fraction bits
   function automatic ang_type atan_q30(input logic [4:0] idx);
      ang_type r;
      r = '0;
      case (idx)
         5'd0:  r = 40'sd843314857;
         5'd1:  r = 40'sd497837829;
         5'd2:  r = 40'sd263043837;
         5'd3:  r = 40'sd133525159;
         5'd4:  r = 40'sd67021687;
         5'd5:  r = 40'sd33543516;
         5'd6:  r = 40'sd16775851;
         5'd7:  r = 40'sd8388437;
         5'd8:  r = 40'sd4194283;
         5'd9:  r = 40'sd2097149;
         5'd10: r = 40'sd1048576;
         5'd11: r = 40'sd524288;
         5'd12: r = 40'sd262144;
         5'd13: r = 40'sd131072;
         5'd14: r = 40'sd65536;
         5'd15: r = 40'sd32768;
         5'd16: r = 40'sd16384;
         5'd17: r = 40'sd8192;
         5'd18: r = 40'sd4096;
         5'd19: r = 40'sd2048;
         5'd20: r = 40'sd1024;
         5'd21: r = 40'sd512;
         5'd22: r = 40'sd256;
         5'd23: r = 40'sd128;
         default: r = '0;
      endcase
      return r;
   endfunction

   // K^2 with 30 fraction bits for n steps, elaboration time only
   function automatic logic [63:0] gain2_q30(input int unsigned n);
      logic [63:0] p;
      p = 64'd1 << 30;
      for (int unsigned i = 0; i < n; i++) begin
         p = p + (p >> (2 * i));
      end
      return p;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/polar_vector_adder_unit.sv */
// polar vector adder top level: angle reduction, two rotation rows, sum, vectoring, output
//
//   channel   direction  handshake             fields
//   request   in         start & !busy         req_angle_a req_mag_a req_angle_b req_mag_b
//   response  out        rsp_valid, one cycle  rsp_sum_magnitude rsp_sum_angle
//
// one request per cycle; busy is tied low.
// the path holds the input registers, two rows of cordic cells (CORDIC_STEPS each, at most 24),
// the sum register, gain multiply (two stages) and output registers.
// synchronous reset clears the valid bits of every stage.
// the receiver cannot stall; each response shows for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module polar_vector_adder_unit #(
   parameter int unsigned CORDIC_STEPS    = 16,
   parameter int unsigned ANGLE_FRAC_BITS = 13
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [15:0] req_angle_a,
   input  wire logic signed [15:0] req_mag_a,
   input  wire logic signed [15:0] req_angle_b,
   input  wire logic signed [15:0] req_mag_b,
   output logic                    rsp_valid,
   output logic [16:0]             rsp_sum_magnitude,
   output logic signed [15:0]      rsp_sum_angle
);

   localparam int unsigned Steps = (CORDIC_STEPS > pva_pkg::TableLen) ?
                                   pva_pkg::TableLen : CORDIC_STEPS;
   localparam int unsigned AShift = 30 - ANGLE_FRAC_BITS;
   // input angle spans 2^(15+AShift); 2*pi exceeds 2^32
   localparam int RedSteps = (AShift > 17) ? int'(AShift) - 17 : 0;
   localparam logic [63:0] GainQ30 = pva_pkg::gain2_q30(Steps);
   localparam logic [63:0] InvK2Full = ((64'd1 << 60) + (GainQ30 >> 1)) / GainQ30;
   localparam logic [31:0] InvK2 = InvK2Full[31:0];
   localparam pva_pkg::ang_type RndA = pva_pkg::ang_type'(64'sd1 <<< (AShift - 1));
   localparam pva_pkg::ang_type LimA = (pva_pkg::PiQ30 + RndA) >>> AShift;
   localparam pva_pkg::ang_type AngHi = pva_pkg::ang_type'(32767);
   localparam pva_pkg::ang_type AngLo = pva_pkg::ang_type'(-32768);
   localparam int unsigned ProdW = pva_pkg::VecW + 32;

   pva_pkg::cell_type rot_a_out, rot_b_out;
   pva_pkg::cell_type vec_in_ff, vec_in_in, vec_out;
   pva_pkg::ang_type  base_q [Steps+1];

   assign busy = 1'b0;

   // reduce one angle into +-pi/2 and seed its rotation word
   function automatic pva_pkg::cell_type seed(input logic v,
                                              input logic signed [15:0] ang,
                                              input logic signed [15:0] mag);
      pva_pkg::cell_type c;
      pva_pkg::ang_type  z;
      pva_pkg::ang_type  w;
      pva_pkg::vec_type  m;
      z = pva_pkg::ang_type'(ang) <<< AShift;
      m = pva_pkg::vec_type'(mag) <<< pva_pkg::GuardBits;
      // binary modulo by 2*pi, largest multiple first; empty when RedSteps is 0
      for (int k = RedSteps - 1; k >= 0; k--) begin
         w = pva_pkg::TwoPiQ30 <<< k;
         if (z >= w) begin
            z = z - w;
         end else if (z <= -w) begin
            z = z + w;
         end
      end
      if (z > pva_pkg::PiQ30) begin
         z = z - pva_pkg::TwoPiQ30;
      end else if (z < -pva_pkg::PiQ30) begin
         z = z + pva_pkg::TwoPiQ30;
      end
      if (z > pva_pkg::HalfPiQ30) begin
         z = z - pva_pkg::PiQ30;
         m = -m;
      end else if (z < -pva_pkg::HalfPiQ30) begin
         z = z + pva_pkg::PiQ30;
         m = -m;
      end
      c.valid = v;
      c.x = m;
      c.y = '0;
      c.z = z;
      return c;
   endfunction

   // input register stage
   pva_pkg::cell_type seed_a_in, seed_b_in, seed_a_ff, seed_b_ff;
   assign seed_a_in = seed(start, req_angle_a, req_mag_a);
   assign seed_b_in = seed(start, req_angle_b, req_mag_b);
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_a_ff.valid <= 1'b0;
         seed_b_ff.valid <= 1'b0;
      end else begin
         seed_a_ff.valid <= seed_a_in.valid;
         seed_b_ff.valid <= seed_b_in.valid;
      end
      seed_a_ff.x <= seed_a_in.x;
      seed_a_ff.y <= seed_a_in.y;
      seed_a_ff.z <= seed_a_in.z;
      seed_b_ff.x <= seed_b_in.x;
      seed_b_ff.y <= seed_b_in.y;
      seed_b_ff.z <= seed_b_in.z;
   end

   pva_chain #(.STEPS(Steps), .VECTORING(1'b0)) u_rot_a (
      .clock(clock), .reset(reset), .chain_in(seed_a_ff), .chain_out(rot_a_out));
   pva_chain #(.STEPS(Steps), .VECTORING(1'b0)) u_rot_b (
      .clock(clock), .reset(reset), .chain_in(seed_b_ff), .chain_out(rot_b_out));

   // sum and fold into the right half plane
   pva_pkg::vec_type sx, sy;
   pva_pkg::ang_type base_in;
   always_comb begin
      sx = rot_a_out.x + rot_b_out.x;
      sy = rot_a_out.y + rot_b_out.y;
      base_in = '0;
      vec_in_in.valid = rot_a_out.valid & rot_b_out.valid;
      vec_in_in.x = sx;
      vec_in_in.y = sy;
      vec_in_in.z = '0;
      if (sx < 0) begin
         base_in = (sy >= 0) ? pva_pkg::PiQ30 : -pva_pkg::PiQ30;
         vec_in_in.x = -sx;
         vec_in_in.y = -sy;
      end
   end

   pva_pkg::ang_type base_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vec_in_ff.valid <= 1'b0;
      end else begin
         vec_in_ff.valid <= vec_in_in.valid;
      end
      vec_in_ff.x <= vec_in_in.x;
      vec_in_ff.y <= vec_in_in.y;
      vec_in_ff.z <= vec_in_in.z;
      base_ff     <= base_in;
   end

   pva_chain #(.STEPS(Steps), .VECTORING(1'b1)) u_vec (
      .clock(clock), .reset(reset), .chain_in(vec_in_ff), .chain_out(vec_out));

   // base angle travels beside the vectoring row
   assign base_q[0] = base_ff;
   for (genvar g = 0; g < Steps; g++) begin : g_base
      pva_pkg::ang_type b_ff;
      always_ff @(posedge clock) begin
         b_ff <= base_q[g];
      end
      assign base_q[g+1] = b_ff;
   end

   // gain removal: two 24x32 partial products, then sum with rounding
   logic [pva_pkg::VecW-1:0] xpos;
   logic [55:0]      plo_in, phi_in, plo_ff, phi_ff;
   logic [ProdW-1:0] prod_in, prod_ff;
   logic             m_valid_ff, m2_valid_ff;
   pva_pkg::ang_type z_ff, z2_ff;
   assign xpos    = (vec_out.x < 0) ? '0 : pva_pkg::VecW'(vec_out.x);
   assign plo_in  = 56'(xpos[23:0]) * 56'(InvK2);
   assign phi_in  = 56'(xpos[pva_pkg::VecW-1:24]) * 56'(InvK2);
   assign prod_in = ProdW'(plo_ff) + (ProdW'(phi_ff) << 24) +
                    (ProdW'(1) << (29 + pva_pkg::GuardBits));
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff  <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else begin
         m_valid_ff  <= vec_out.valid;
         m2_valid_ff <= m_valid_ff;
      end
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      prod_ff <= prod_in;
      z_ff    <= base_q[Steps] + vec_out.z;
      z2_ff   <= z_ff;
   end

   // rounding, saturation, angle clamp
   logic [ProdW-1:0]   magw;
   logic [16:0]        mag_in;
   pva_pkg::ang_type   ang;
   logic signed [15:0] ang_in;
   always_comb begin
      magw = prod_ff >> (30 + pva_pkg::GuardBits);
      mag_in = (magw > ProdW'(pva_pkg::MagMax)) ? 17'(pva_pkg::MagMax) : magw[16:0];
      ang = (z2_ff + RndA) >>> AShift;
      if (ang > LimA) ang = LimA;
      if (ang < -LimA) ang = -LimA;
      if (ang > AngHi) ang = AngHi;
      if (ang < AngLo) ang = AngLo;
      ang_in = (mag_in == '0) ? '0 : ang[15:0];
   end

   logic               rsp_valid_ff;
   logic [16:0]        mag_ff;
   logic signed [15:0] angle_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= m2_valid_ff;
      end
      mag_ff   <= mag_in;
      angle_ff <= ang_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sum_magnitude = mag_ff;
   assign rsp_sum_angle     = angle_ff;

endmodule
`default_nettype wire

/* rtl/core/pva_cell.sv */
// one cordic cell: a single micro-rotation, registered
`timescale 1ns / 1ps
`default_nettype none
module pva_cell #(
   parameter int unsigned STEP = 0,
   parameter bit          VECTORING = 1'b0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pva_pkg::cell_type cell_in,
   output pva_pkg::cell_type      cell_out
);

   pva_pkg::cell_type cell_ff;
   pva_pkg::cell_type cell_in_nx;
   pva_pkg::vec_type  dx;
   pva_pkg::vec_type  dy;
   pva_pkg::ang_type  at;
   logic              go_pos;

   // micro-rotation toward zero angle or zero y
   always_comb begin
      dx = cell_in.y >>> STEP;
      dy = cell_in.x >>> STEP;
      at = pva_pkg::atan_q30(5'(STEP));
      go_pos = VECTORING ? (cell_in.y > 0) : (cell_in.z >= 0);
      cell_in_nx = cell_in;
      if (VECTORING ? go_pos : 1'b0) begin
         cell_in_nx.x = cell_in.x + dx;
         cell_in_nx.y = cell_in.y - dy;
         cell_in_nx.z = cell_in.z + at;
      end else if (VECTORING) begin
         cell_in_nx.x = cell_in.x - dx;
         cell_in_nx.y = cell_in.y + dy;
         cell_in_nx.z = cell_in.z - at;
      end else if (go_pos) begin
         cell_in_nx.x = cell_in.x - dx;
         cell_in_nx.y = cell_in.y + dy;
         cell_in_nx.z = cell_in.z - at;
      end else begin
         cell_in_nx.x = cell_in.x + dx;
         cell_in_nx.y = cell_in.y - dy;
         cell_in_nx.z = cell_in.z + at;
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in_nx.valid;
      end
      cell_ff.x <= cell_in_nx.x;
      cell_ff.y <= cell_in_nx.y;
      cell_ff.z <= cell_in_nx.z;
   end

   assign cell_out = cell_ff;

endmodule
`default_nettype wire

/* rtl/core/pva_chain.sv */
// row of cordic cells, rotation or vectoring
`timescale 1ns / 1ps
`default_nettype none
module pva_chain #(
   parameter int unsigned STEPS = 16,
   parameter bit          VECTORING = 1'b0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pva_pkg::cell_type chain_in,
   output pva_pkg::cell_type      chain_out
);

   pva_pkg::cell_type link [STEPS+1];

   assign link[0] = chain_in;

   // cells hand their word to the next one every cycle
   for (genvar g = 0; g < STEPS; g++) begin : g_cell
      pva_cell #(.STEP(g), .VECTORING(VECTORING)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cell_in (link[g]),
         .cell_out(link[g+1])
      );
   end

   assign chain_out = link[STEPS];

endmodule
`default_nettype wire

/* rtl/core/pva_checker.sv */
// port-level checker for the polar vector adder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module pva_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               rsp_valid,
   input wire logic [16:0]        rsp_sum_magnitude,
   input wire logic signed [15:0] rsp_sum_angle
);

   // zero length gives zero angle
   a_zero_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sum_magnitude == 17'd0 |-> rsp_sum_angle == 16'sd0)
      else $error("nonzero angle on zero length");

   // angle within +-pi
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sum_angle <= 16'sd25736 && rsp_sum_angle >= -16'sd25736))
      else $error("angle out of range");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response right after reset");

   // block never blocks requests
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy)
      else $error("busy asserted");

endmodule

bind polar_vector_adder_unit pva_checker u_pva_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_sum_magnitude(rsp_sum_magnitude),
   .rsp_sum_angle(rsp_sum_angle));
`default_nettype wire
